// ===== design/trp_pkg.sv =====
// Shared types, tag type codes and helper functions for the tag record parser.
package trp_pkg;

	localparam int unsigned TRP_QDEPTH = 4;

	localparam logic [6:0] TY_HASH    = 7'h01;
	localparam logic [6:0] TY_STR     = 7'h02;
	localparam logic [6:0] TY_U32     = 7'h03;
	localparam logic [6:0] TY_BOOL    = 7'h05;
	localparam logic [6:0] TY_BARR    = 7'h06;
	localparam logic [6:0] TY_BLOB    = 7'h07;
	localparam logic [6:0] TY_U16     = 7'h08;
	localparam logic [6:0] TY_U8      = 7'h09;
	localparam logic [6:0] TY_U64     = 7'h0B;
	localparam logic [6:0] SHORT_LO   = 7'h11;
	localparam logic [6:0] SHORT_HI   = 7'h26;
	localparam logic [6:0] SHORT_BASE = 7'h10;

	localparam logic [1:0] K_NAME  = 2'd0;
	localparam logic [1:0] K_BYTE  = 2'd1;
	localparam logic [1:0] K_WHOLE = 2'd2;
	localparam logic [1:0] K_NONE  = 2'd3;

	// A stream byte together with its reading as a type byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
		logic [6:0] tag_type;
		logic [4:0] short_len;
		logic       has_id;
	} cls_t;

	function automatic logic unsupported(input logic [6:0] t);
		logic ok;
		ok = (t >= TY_HASH && t <= TY_U32) || (t >= TY_BOOL && t <= TY_U8) || (t == TY_U64);
		return !ok;
	endfunction

	// Index of the last byte of an integer value.
	function automatic logic [2:0] int_last_pos(input logic [6:0] t);
		logic [2:0] p;
		unique case (t)
			TY_U32:  p = 3'd3;
			TY_U16:  p = 3'd1;
			TY_U64:  p = 3'd7;
			default: p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

// ===== design/trp_in_if.sv =====
// Input channel carrying raw stream bytes.
interface trp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

// ===== design/trp_out_if.sv =====
// Output channel carrying parsed results.
interface trp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        status;
	logic [6:0]  tag_type;
	logic [7:0]  tag_id;
	logic [63:0] data_value;
	logic        tag_last;

	modport source (output valid, output kind, output status, output tag_type,
		output tag_id, output data_value, output tag_last, input ready);
	modport sink (input valid, input kind, input status, input tag_type,
		input tag_id, input data_value, input tag_last, output ready);
endinterface

// ===== design/trp_front.sv =====
// Front stage: takes stream beats and decodes each byte as a possible type byte.
module trp_front (
	input  logic          clk,
	input  logic          arst_n,
	trp_in_if.sink        stream,
	output logic          cls_valid,
	input  logic          cls_ready,
	output trp_pkg::cls_t cls_data
);
	import trp_pkg::*;

	logic       vld_s1;
	cls_t       cls_s1;
	cls_t       cls_d;
	logic [6:0] t;

	assign t = stream.data_byte[6:0];

	always_comb begin
		cls_d.data_byte = stream.data_byte;
		cls_d.restart   = stream.restart;
		cls_d.has_id    = stream.data_byte[7];
		if (t >= SHORT_LO && t <= SHORT_HI) begin
			cls_d.tag_type  = TY_STR;
			cls_d.short_len = 5'(t - SHORT_BASE);
		end else begin
			cls_d.tag_type  = t;
			cls_d.short_len = '0;
		end
	end

	assign stream.ready = !vld_s1 || cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			vld_s1 <= 1'b1;
		end else if (cls_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			cls_s1 <= cls_d;
		end
	end

	assign cls_valid = vld_s1;
	assign cls_data  = cls_s1;

endmodule

// ===== design/trp_fifo.sv =====
// Short queue between the front and back stages.
module trp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/trp_back.sv =====
// Back stage: the tag parse state machine and the result register.
module trp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cls_valid,
	output logic          cls_ready,
	input  trp_pkg::cls_t cls_data,
	trp_out_if.source     result
);
	import trp_pkg::*;

	localparam logic [3:0] PH_TYPE   = 4'd0;
	localparam logic [3:0] PH_ID     = 4'd1;
	localparam logic [3:0] PH_NLEN   = 4'd2;
	localparam logic [3:0] PH_NID    = 4'd3;
	localparam logic [3:0] PH_NAME   = 4'd4;
	localparam logic [3:0] PH_VLEN   = 4'd5;
	localparam logic [3:0] PH_VINT   = 4'd6;
	localparam logic [3:0] PH_VBYTES = 4'd7;
	localparam logic [3:0] PH_SKIP   = 4'd8;

	logic [3:0]  phase_q, n_phase, ph;
	logic [6:0]  type_q, n_type;
	logic [7:0]  id_q, n_id;
	logic [4:0]  short_q, n_short;
	logic [31:0] rem_q, n_rem, rem_dec;
	logic [2:0]  pos_q, n_pos;
	logic [63:0] acc_q, n_acc, acc_or;

	logic        sv_ends;
	logic [3:0]  sv_phase;
	logic [31:0] sv_rem;

	logic        emit;
	logic [1:0]  e_kind;
	logic [63:0] e_value;
	logic        e_last;

	logic [15:0] len16;
	logic [31:0] len32;
	logic        fire;

	logic        ov_q;
	logic [1:0]  kind_q;
	logic        status_q;
	logic [6:0]  tag_type_q;
	logic [7:0]  tag_id_q;
	logic [63:0] value_q;
	logic        last_q;

	assign cls_ready = !ov_q || result.ready;
	assign fire      = cls_valid && cls_ready;

	// Set-up of the value once the header is complete.
	always_comb begin
		sv_ends  = 1'b0;
		sv_rem   = '0;
		sv_phase = PH_VINT;
		if (unsupported(type_q)) begin
			sv_ends  = 1'b1;
			sv_phase = PH_TYPE;
		end else if (type_q == TY_HASH) begin
			sv_rem   = 32'd16;
			sv_phase = PH_VBYTES;
		end else if (type_q == TY_STR && short_q != '0) begin
			sv_rem   = {27'd0, short_q};
			sv_phase = PH_VBYTES;
		end else if (type_q == TY_STR || type_q == TY_BARR || type_q == TY_BLOB) begin
			sv_phase = PH_VLEN;
		end
	end

	assign acc_or  = acc_q | ({56'd0, cls_data.data_byte} << {pos_q, 3'b000});
	assign rem_dec = rem_q - 32'd1;
	assign len16   = {cls_data.data_byte, rem_q[7:0]};
	assign len32   = acc_or[31:0];
	assign ph      = cls_data.restart ? PH_TYPE : phase_q;

	always_comb begin
		n_phase = ph;
		n_type  = type_q;
		n_id    = id_q;
		n_short = short_q;
		n_rem   = rem_q;
		n_pos   = pos_q;
		n_acc   = acc_q;
		emit    = 1'b0;
		e_kind  = K_NONE;
		e_value = '0;
		e_last  = 1'b0;
		unique case (ph)
			PH_TYPE: begin
				n_id    = '0;
				n_rem   = '0;
				n_pos   = '0;
				n_acc   = '0;
				n_type  = cls_data.tag_type;
				n_short = cls_data.short_len;
				n_phase = cls_data.has_id ? PH_ID : PH_NLEN;
			end
			PH_ID, PH_NID: begin
				n_id    = cls_data.data_byte;
				n_acc   = '0;
				n_pos   = '0;
				n_short = '0;
				n_rem   = sv_rem;
				n_phase = sv_phase;
				emit    = sv_ends;
				e_last  = 1'b1;
			end
			PH_NLEN: begin
				if (pos_q == 3'd0) begin
					n_rem = {24'd0, cls_data.data_byte};
					n_pos = 3'd1;
				end else begin
					n_pos = '0;
					n_rem = {16'd0, len16};
					if (len16 == 16'd1) begin
						n_phase = PH_NID;
					end else if (len16 == 16'd0) begin
						n_acc   = '0;
						n_short = '0;
						n_rem   = sv_rem;
						n_phase = sv_phase;
						emit    = sv_ends;
						e_last  = 1'b1;
					end else begin
						n_phase = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				n_rem   = rem_dec;
				emit    = 1'b1;
				e_kind  = K_NAME;
				e_value = {56'd0, cls_data.data_byte};
				if (rem_q == 32'd1) begin
					n_acc   = '0;
					n_pos   = '0;
					n_short = '0;
					n_rem   = sv_rem;
					n_phase = sv_phase;
					e_last  = sv_ends;
				end
			end
			PH_VLEN: begin
				n_acc = acc_or;
				if (pos_q != ((type_q == TY_BLOB) ? 3'd3 : 3'd1)) begin
					n_pos = pos_q + 3'd1;
				end else begin
					n_acc = '0;
					n_pos = '0;
					if (type_q == TY_BARR) begin
						// A bool array skips count/8+1 bytes.
						n_rem   = {3'd0, len32[31:3]} + 32'd1;
						n_phase = PH_SKIP;
					end else if (len32 == '0) begin
						n_phase = PH_TYPE;
						emit    = 1'b1;
						e_last  = 1'b1;
					end else begin
						n_rem   = len32;
						n_phase = PH_VBYTES;
					end
				end
			end
			PH_VINT: begin
				if (pos_q != int_last_pos(type_q)) begin
					n_acc = acc_or;
					n_pos = pos_q + 3'd1;
				end else begin
					n_acc   = '0;
					n_pos   = '0;
					n_phase = PH_TYPE;
					emit    = 1'b1;
					e_kind  = K_WHOLE;
					e_last  = 1'b1;
					if (type_q == TY_BOOL) begin
						e_value = {63'd0, acc_or == 64'd1};
					end else begin
						e_value = acc_or;
					end
				end
			end
			PH_VBYTES: begin
				n_rem   = rem_dec;
				emit    = 1'b1;
				e_kind  = K_BYTE;
				e_value = {56'd0, cls_data.data_byte};
				e_last  = (rem_q == 32'd1);
				if (rem_q == 32'd1) begin
					n_phase = PH_TYPE;
				end
			end
			PH_SKIP: begin
				n_rem = rem_dec;
				if (rem_q == 32'd1) begin
					n_phase = PH_TYPE;
					emit    = 1'b1;
					e_last  = 1'b1;
				end
			end
			default: begin
				n_phase = PH_TYPE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			type_q  <= '0;
			id_q    <= '0;
			short_q <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			acc_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= n_phase;
				type_q  <= n_type;
				id_q    <= n_id;
				short_q <= n_short;
				rem_q   <= n_rem;
				pos_q   <= n_pos;
				acc_q   <= n_acc;
			end
			if (fire && emit) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q     <= e_kind;
			status_q   <= unsupported(type_q);
			tag_type_q <= type_q;
			tag_id_q   <= n_id;
			value_q    <= e_value;
			last_q     <= e_last;
		end
	end

	assign result.valid      = ov_q;
	assign result.kind       = kind_q;
	assign result.status     = status_q;
	assign result.tag_type   = tag_type_q;
	assign result.tag_id     = tag_id_q;
	assign result.data_value = value_q;
	assign result.tag_last   = last_q;

endmodule

// ===== design/tag_record_parser_top.sv =====
// Top level of the typed tag record parser.
// The parser takes one stream byte per beat and sustains one byte per clock cycle:
// every byte needs a single update of the parse state in the back stage, so the
// rate is one beat per cycle while the result side keeps taking beats. A byte
// passes a decode register in the front stage, a queue of QUEUE_DEPTH entries and
// the parse state machine, and its result, if it has one, is held in the output
// register. Header bytes, length bytes and the bytes of integers still being built
// give no result unless the tag ends on them; each result carries the tag type, id
// and status of the tag that it belongs to.
// A beat with restart set drops any partial tag and is read as a type byte.
module tag_record_parser_top #(
	parameter int unsigned QUEUE_DEPTH = trp_pkg::TRP_QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	trp_in_if.sink    stream,
	trp_out_if.source result
);
	import trp_pkg::*;

	logic cls_valid_f;
	logic cls_ready_f;
	cls_t cls_data_f;
	logic cls_valid_b;
	logic cls_ready_b;
	cls_t cls_data_b;

	trp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.cls_valid (cls_valid_f),
		.cls_ready (cls_ready_f),
		.cls_data  (cls_data_f)
	);

	trp_fifo #(
		.WIDTH ($bits(cls_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cls_valid_f),
		.push_ready (cls_ready_f),
		.push_data  (cls_data_f),
		.pop_valid  (cls_valid_b),
		.pop_ready  (cls_ready_b),
		.pop_data   (cls_data_b)
	);

	trp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid_b),
		.cls_ready (cls_ready_b),
		.cls_data  (cls_data_b),
		.result    (result)
	);

endmodule

// ===== tb/sv/trp_result_checker.sv =====
// Result checker for the tag record parser: predicts each result and compares it.
`timescale 1ns / 1ps

module trp_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	trp_in_if           stream,
	trp_out_if          result,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked
);
	import trp_pkg::*;

	typedef enum logic [3:0] {
		PH_TYPE, PH_ID, PH_NLEN, PH_NID, PH_NAME, PH_VLEN, PH_VINT, PH_VBYTES, PH_SKIP
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        status;
		logic [6:0]  tag_type;
		logic [7:0]  tag_id;
		logic [63:0] data_value;
		logic        tag_last;
	} tag_result_t;

	// Parse state of the predicted stream.
	parse_phase_t phase;
	logic [6:0]   cur_type;
	logic [7:0]   cur_id;
	logic [31:0]  remaining;
	logic [2:0]   pos;
	logic [63:0]  acc;

	tag_result_t  expected_results[$];
	int unsigned  errs;
	int unsigned  n_checked;

	function automatic logic type_flagged(input logic [6:0] t);
		case (t)
			TY_HASH, TY_STR, TY_U32, TY_BOOL, TY_BARR, TY_BLOB, TY_U16, TY_U8, TY_U64: return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	function automatic int int_width(input logic [6:0] t);
		case (t)
			TY_U32:  return 4;
			TY_U16:  return 2;
			TY_U64:  return 8;
			default: return 1;
		endcase
	endfunction

	function automatic tag_result_t make_result(input logic [1:0] kind, input logic [63:0] value,
			input logic last);
		tag_result_t r;
		r.kind       = kind;
		r.status     = type_flagged(cur_type);
		r.tag_type   = cur_type;
		r.tag_id     = cur_id;
		r.data_value = value;
		r.tag_last   = last;
		return r;
	endfunction

	// Header complete: pick how the value is read. True when the tag ends here.
	function automatic logic begin_value();
		logic [7:0] short_len;
		short_len = acc[7:0];
		acc       = '0;
		pos       = '0;
		remaining = '0;
		if (type_flagged(cur_type)) begin
			phase = PH_TYPE;
			return 1'b1;
		end
		if (cur_type == TY_HASH) begin
			remaining = 32'd16;
			phase     = PH_VBYTES;
		end else if (cur_type == TY_STR && short_len != 8'd0) begin
			remaining = 32'(short_len);
			phase     = PH_VBYTES;
		end else if (cur_type == TY_STR || cur_type == TY_BARR || cur_type == TY_BLOB) begin
			phase = PH_VLEN;
		end else begin
			phase = PH_VINT;
		end
		return 1'b0;
	endfunction

	function automatic logic parse_step(input logic [7:0] b, input logic rst,
			output tag_result_t r);
		logic [6:0]  t;
		logic [31:0] len;
		logic [63:0] v;
		int          need;
		r = '0;
		if (rst)
			phase = PH_TYPE;
		case (phase)
			PH_TYPE: begin
				t         = b[6:0];
				cur_id    = '0;
				remaining = '0;
				pos       = '0;
				acc       = '0;
				// Short strings become plain strings; their length waits in the accumulator.
				if (t >= SHORT_LO && t <= SHORT_HI) begin
					acc      = 64'(t - SHORT_BASE);
					cur_type = TY_STR;
				end else begin
					cur_type = t;
				end
				phase = b[7] ? PH_ID : PH_NLEN;
				return 1'b0;
			end
			PH_ID, PH_NID: begin
				cur_id = b;
				if (begin_value()) begin
					r = make_result(K_NONE, '0, 1'b1);
					return 1'b1;
				end
				return 1'b0;
			end
			PH_NLEN: begin
				if (pos == 3'd0) begin
					remaining = 32'(b);
					pos       = 3'd1;
					return 1'b0;
				end
				remaining[15:8] = b;
				pos             = '0;
				if (remaining == 32'd1) begin
					phase = PH_NID;
					return 1'b0;
				end
				if (remaining == 32'd0) begin
					if (begin_value()) begin
						r = make_result(K_NONE, '0, 1'b1);
						return 1'b1;
					end
					return 1'b0;
				end
				phase = PH_NAME;
				return 1'b0;
			end
			PH_NAME: begin
				remaining = remaining - 32'd1;
				if (remaining == 32'd0)
					r = make_result(K_NAME, 64'(b), begin_value());
				else
					r = make_result(K_NAME, 64'(b), 1'b0);
				return 1'b1;
			end
			PH_VLEN: begin
				need = (cur_type == TY_BLOB) ? 4 : 2;
				acc  = acc | (64'(b) << (8 * pos));
				if (int'(pos) + 1 < need) begin
					pos = pos + 3'd1;
					return 1'b0;
				end
				len = acc[31:0];
				acc = '0;
				pos = '0;
				if (cur_type == TY_BARR) begin
					remaining = (len >> 3) + 32'd1;
					phase     = PH_SKIP;
					return 1'b0;
				end
				if (len == 32'd0) begin
					phase = PH_TYPE;
					r     = make_result(K_NONE, '0, 1'b1);
					return 1'b1;
				end
				remaining = len;
				phase     = PH_VBYTES;
				return 1'b0;
			end
			PH_VINT: begin
				need = int_width(cur_type);
				acc  = acc | (64'(b) << (8 * pos));
				if (int'(pos) + 1 < need) begin
					pos = pos + 3'd1;
					return 1'b0;
				end
				v = acc;
				if (cur_type == TY_BOOL)
					v = (v == 64'd1) ? 64'd1 : 64'd0;
				phase = PH_TYPE;
				pos   = '0;
				acc   = '0;
				r     = make_result(K_WHOLE, v, 1'b1);
				return 1'b1;
			end
			PH_VBYTES: begin
				remaining = remaining - 32'd1;
				if (remaining == 32'd0) begin
					phase = PH_TYPE;
					r     = make_result(K_BYTE, 64'(b), 1'b1);
				end else begin
					r = make_result(K_BYTE, 64'(b), 1'b0);
				end
				return 1'b1;
			end
			PH_SKIP: begin
				remaining = remaining - 32'd1;
				if (remaining == 32'd0) begin
					phase = PH_TYPE;
					r     = make_result(K_NONE, '0, 1'b1);
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				phase = PH_TYPE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: result %0d, %s expected 0x%0h, got 0x%0h",
				$time, n_checked, field, want_v, got_v);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tag_result_t want;
		if (!arst_n) begin
			phase     = PH_TYPE;
			cur_type  = '0;
			cur_id    = '0;
			remaining = '0;
			pos       = '0;
			acc       = '0;
			expected_results.delete();
			errs      = 0;
			n_checked = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (stream.valid && stream.ready) begin
				if (parse_step(stream.data_byte, stream.restart, want))
					expected_results.push_back(want);
			end
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, got kind %0d value 0x%0h",
						$time, result.kind, result.data_value);
					errs++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 64'(want.kind), 64'(result.kind));
					check_field("status", 64'(want.status), 64'(result.status));
					check_field("tag_type", 64'(want.tag_type), 64'(result.tag_type));
					check_field("tag_id", 64'(want.tag_id), 64'(result.tag_id));
					check_field("data_value", want.data_value, result.data_value);
					check_field("tag_last", 64'(want.tag_last), 64'(result.tag_last));
				end
				n_checked++;
			end
			fail_count <= errs;
			pending    <= expected_results.size();
			checked    <= n_checked;
		end
	end

endmodule

// ===== tb/sv/tb_tag_record_parser_top.sv =====
// Testbench top for the tag record parser: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps

module tb_tag_record_parser_top;
	import trp_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned DRAIN_LIMIT   = 20000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned RANDOM_BYTES  = 1200;
	localparam int unsigned PAYLOAD_CAP   = 1024;
	localparam logic [6:0]  VALUE_TYPES [9] = '{TY_HASH, TY_STR, TY_U32, TY_BOOL, TY_BARR,
		TY_BLOB, TY_U16, TY_U8, TY_U64};

	logic clk;
	logic arst_n;

	trp_in_if  stream ();
	trp_out_if result ();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned tags_sent = 0;
	int unsigned tags_cut = 0;
	int unsigned noise_bursts = 0;

	bit calm;
	bit hold_req;
	bit need_restart;
	bit tag_whole;
	logic [7:0] tag_bytes[$];

	tag_record_parser_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.result (result)
	);

	trp_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding.", pending);
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, a calm stretch, and one long hold-off on request.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				result.ready <= 1'b0;
				hold_left--;
			end else begin
				result.ready <= calm || ($urandom_range(99) >= 25);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic r);
		if (!calm) begin
			while ($urandom_range(99) < 25) begin
				stream.valid <= 1'b0;
				@(posedge clk);
			end
		end
		stream.valid     <= 1'b1;
		stream.data_byte <= b;
		stream.restart   <= r;
		do @(posedge clk); while (!stream.ready);
		bytes_sent++;
	endtask

	task automatic put_le(input logic [63:0] value, input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			tag_bytes.push_back(value[8*i +: 8]);
	endtask

	// Payloads longer than the cap are never sent whole; such a tag is cut short.
	task automatic put_random(input int unsigned n);
		if (n > PAYLOAD_CAP)
			tag_whole = 1'b0;
		for (int unsigned i = 0; i < n && i < PAYLOAD_CAP; i++)
			tag_bytes.push_back(8'($urandom));
	endtask

	task automatic build_tag(input logic [7:0] type_byte, input logic [7:0] id,
			input int unsigned name_len, input logic [63:0] value, input int unsigned val_len);
		logic [6:0] t;
		t = type_byte[6:0];
		tag_bytes.delete();
		tag_whole = 1'b1;
		tag_bytes.push_back(type_byte);
		if (type_byte[7]) begin
			tag_bytes.push_back(id);
		end else begin
			put_le(64'(name_len), 2);
			if (name_len == 1)
				tag_bytes.push_back(id);
			else
				put_random(name_len);
		end
		if (t >= SHORT_LO && t <= SHORT_HI) begin
			put_random(int'(t - SHORT_BASE));
		end else begin
			case (t)
				TY_HASH: put_random(16);
				TY_STR: begin
					put_le(64'(val_len), 2);
					put_random(val_len);
				end
				TY_BLOB: begin
					put_le(64'(val_len), 4);
					put_random(val_len);
				end
				TY_BARR: begin
					put_le(64'(val_len), 2);
					put_random(val_len / 8 + 1);
				end
				TY_U32:  put_le(value, 4);
				TY_U16:  put_le(value, 2);
				TY_U64:  put_le(value, 8);
				TY_U8, TY_BOOL: put_le(value, 1);
				default: ;
			endcase
		end
	endtask

	task automatic send_bytes(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			push_byte(tag_bytes[i], i == 0 && (need_restart || $urandom_range(9) == 0));
		need_restart = (count < tag_bytes.size()) || !tag_whole;
		if (need_restart)
			tags_cut++;
		tags_sent++;
	endtask

	task automatic send_tag();
		int unsigned count;
		count = tag_bytes.size();
		if (!tag_whole)
			count = $urandom_range(1, count < 40 ? count : 40);
		else if (count > 1 && $urandom_range(99) < 6)
			count = $urandom_range(1, count - 1);
		send_bytes(count);
	endtask

	task automatic random_tag();
		logic [6:0]  t;
		logic [7:0]  id;
		logic [63:0] value;
		int unsigned pick;
		int unsigned name_len;
		int unsigned len;
		pick = $urandom_range(99);
		if (pick < 8)
			t = 7'($urandom_range(127));
		else if (pick < 22)
			t = 7'($urandom_range(int'(SHORT_LO), int'(SHORT_HI)));
		else
			t = VALUE_TYPES[$urandom_range(8)];
		id = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 30)
			name_len = 1;
		else if (pick < 38)
			name_len = 0;
		else if (pick < 95)
			name_len = $urandom_range(2, 8);
		else
			name_len = $urandom_range(65535);
		pick = $urandom_range(99);
		if (pick < 10)
			len = 0;
		else if (pick < 85)
			len = $urandom_range(1, 24);
		else if (pick < 95)
			len = $urandom_range(25, 400);
		else
			len = (t == TY_BLOB) ? $urandom : $urandom_range(65535);
		value = {$urandom, $urandom};
		if (t == TY_BOOL && $urandom_range(1) == 1)
			value = 64'd1;
		build_tag({1'($urandom_range(1)), t}, id, name_len, value, len);
		send_tag();
	endtask

	// Stop offering beats until every predicted result has been taken.
	task automatic wait_drained(input int unsigned max_cycles);
		int unsigned waited;
		waited = 0;
		stream.valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < max_cycles);
	endtask

	task automatic directed_tag(input logic [7:0] type_byte, input logic [7:0] id,
			input int unsigned name_len, input logic [63:0] value, input int unsigned val_len);
		build_tag(type_byte, id, name_len, value, val_len);
		send_bytes(tag_bytes.size());
	endtask

	initial begin
		int unsigned directed_bytes;
		bit hold_done;
		bit pause_done;
		hold_done        = 1'b0;
		pause_done       = 1'b0;
		calm             = 1'b0;
		hold_req         = 1'b0;
		need_restart     = 1'b0;
		tag_whole        = 1'b1;
		arst_n           <= 1'b0;
		stream.valid     <= 1'b0;
		stream.data_byte <= 8'h00;
		stream.restart   <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every value type, the field extremes and each flagged type.
		directed_tag({1'b1, TY_HASH}, 8'h00, 0, 64'd0, 0);
		directed_tag({1'b1, TY_STR}, 8'hFF, 0, 64'd0, 0);
		directed_tag({1'b1, TY_STR}, 8'h5A, 0, 64'd0, 3);
		directed_tag({1'b1, SHORT_LO}, 8'h11, 0, 64'd0, 0);
		directed_tag({1'b0, SHORT_HI}, 8'h00, 2, 64'd0, 0);
		directed_tag({1'b1, TY_U32}, 8'h01, 0, 64'hFFFF_FFFF, 0);
		directed_tag({1'b0, TY_U16}, 8'h80, 1, 64'h00A5, 0);
		directed_tag({1'b1, TY_U8}, 8'h02, 0, 64'd0, 0);
		directed_tag({1'b1, TY_U64}, 8'h03, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		directed_tag({1'b1, TY_U64}, 8'h04, 0, 64'h8000_0000_0000_0001, 0);
		directed_tag({1'b1, TY_BOOL}, 8'h05, 0, 64'd1, 0);
		directed_tag({1'b1, TY_BOOL}, 8'h06, 0, 64'd2, 0);
		directed_tag({1'b0, TY_BOOL}, 8'h07, 1, 64'd0, 0);
		directed_tag({1'b1, TY_BARR}, 8'h08, 0, 64'd0, 0);
		directed_tag({1'b1, TY_BARR}, 8'h09, 0, 64'd0, 15);
		directed_tag({1'b1, TY_BLOB}, 8'h0A, 0, 64'd0, 0);
		directed_tag({1'b0, TY_BLOB}, 8'h00, 4, 64'd0, 2);
		directed_tag({1'b0, TY_U8}, 8'h00, 0, 64'hC3, 0);
		directed_tag({1'b0, TY_U8}, 8'h00, 258, 64'h7E, 0);
		// Float, BSOB and unknown codes end with their header.
		directed_tag({1'b1, 7'h04}, 8'h0B, 0, 64'd0, 0);
		directed_tag({1'b0, 7'h0A}, 8'h00, 3, 64'd0, 0);
		directed_tag({1'b0, 7'h7F}, 8'h00, 0, 64'd0, 0);
		directed_tag({1'b0, 7'h04}, 8'h0C, 1, 64'd0, 0);
		directed_tag({1'b1, 7'h00}, 8'h0D, 0, 64'd0, 0);
		directed_tag({1'b1, 7'h0C}, 8'h0E, 0, 64'd0, 0);
		directed_tag({1'b1, 7'h10}, 8'h0F, 0, 64'd0, 0);
		directed_tag({1'b1, 7'h27}, 8'h10, 0, 64'd0, 0);
		directed_tag({1'b1, 7'h7F}, 8'hFE, 0, 64'd0, 0);
		// A tag dropped halfway through by a restart beat.
		build_tag({1'b1, TY_U32}, 8'h12, 0, 64'h1234_5678, 0);
		send_bytes(4);
		directed_tag({1'b1, TY_U16}, 8'h13, 0, 64'hBEEF, 0);
		wait_drained(DRAIN_LIMIT);
		directed_bytes = bytes_sent;

		while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
			if (!hold_done && bytes_sent - directed_bytes >= 300) begin
				// Results back up behind the stalled receiver until the input stalls.
				hold_done = 1'b1;
				hold_req  = 1'b1;
				repeat (4)
					directed_tag({1'b1, TY_STR}, 8'($urandom), 0, 64'd0, 40);
			end
			if (!pause_done && bytes_sent - directed_bytes >= 1100) begin
				pause_done = 1'b1;
				wait_drained(DRAIN_LIMIT);
			end
			calm = (bytes_sent - directed_bytes >= 600) && (bytes_sent - directed_bytes < 900);
			if ($urandom_range(99) < 5) begin
				noise_bursts++;
				repeat ($urandom_range(1, 8))
					push_byte(8'($urandom), $urandom_range(3) == 0);
				need_restart = 1'b1;
			end else begin
				random_tag();
			end
		end
		calm = 1'b0;

		wait_drained(DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending != 0)
			$display("%0t: %0d expected results never arrived", $time, pending);
		$display("Sent %0d stream bytes in %0d tags (%0d cut short) and %0d noise bursts.",
			bytes_sent, tags_sent, tags_cut, noise_bursts);
		$display("Checked %0d result beats, %0d mismatches.", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== tag_record_parser_top.f =====
design/trp_pkg.sv
design/trp_in_if.sv
design/trp_out_if.sv
design/trp_front.sv
design/trp_fifo.sv
design/trp_back.sv
design/tag_record_parser_top.sv
tb/sv/trp_result_checker.sv
tb/sv/tb_tag_record_parser_top.sv
